@@ hw/rtl/mexp_pkg.sv @@
// Package for the modular exponentiation block: widths, constants and the
// command and status words between controller and datapath. No dependencies.
`default_nettype none

package mexp_pkg;

  // Field widths.
  localparam int unsigned WordW    = 32;
  localparam int unsigned ModW     = 31;
  localparam int unsigned ExpBits  = 32;
  localparam int unsigned BitCntW  = $clog2(ExpBits);

  // A product of two residues fits in twice the modulus width.
  localparam int unsigned ProdW    = 2 * ModW;
  localparam int unsigned RedSteps = ProdW;
  localparam int unsigned RedCntW  = $clog2(RedSteps);

  localparam logic [ModW-1:0] ModulusReset = ModW'(1000000009);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture base and exponent, preset the running value
    logic mul_sq;    // product of running value with itself
    logic mul_b;     // product of running value and reduced base
    logic red_step;  // one restoring reduction step
    logic wr_b;      // remainder becomes the reduced base
    logic wr_r;      // remainder becomes the running value
    logic shift_e;   // move to the next exponent bit
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic red_last;  // this reduction step is the final one
    logic e_msb;     // exponent bit under scan
  } stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/mexp_dp.sv @@
// Datapath of the modular exponentiation block: modulus register, one
// 31x31 multiplier and a bit-serial reducer. Depends on mexp_pkg.
`default_nettype none

module mexp_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          modulus_we_i,
  input  wire logic [mexp_pkg::ModW-1:0]     modulus_i,
  input  wire logic [mexp_pkg::WordW-1:0]    base_i,
  input  wire logic [mexp_pkg::ExpBits-1:0]  exponent_i,
  input  wire mexp_pkg::cmd_t                cmd_i,
  output mexp_pkg::stat_t                    stat_o,
  output logic [mexp_pkg::ModW-1:0]          power_o
);

  logic [mexp_pkg::ModW-1:0]     mod_q;
  logic [mexp_pkg::ProdW-1:0]    prod_q, prod_d;
  logic [mexp_pkg::ModW-1:0]     rem_q, rem_d;
  logic [mexp_pkg::ModW-1:0]     r_q, r_d;
  logic [mexp_pkg::ModW-1:0]     b_q, b_d;
  logic [mexp_pkg::ExpBits-1:0]  e_q, e_d;
  logic [mexp_pkg::RedCntW-1:0]  red_cnt_q, red_cnt_d;
  logic [mexp_pkg::ModW:0]       trial;
  logic [mexp_pkg::ModW:0]       trial_sub;
  logic [mexp_pkg::ModW-1:0]     mul_a;

  // Modulus register, written by the configuration port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= mexp_pkg::ModulusReset;
    end else if (modulus_we_i) begin
      mod_q <= modulus_i;
    end
  end

  // One restoring step: bring in the next product bit, subtract if it fits.
  assign trial     = {rem_q, prod_q[mexp_pkg::ProdW-1]};
  assign trial_sub = trial - {1'b0, mod_q};

  // Second multiplier operand.
  assign mul_a = cmd_i.mul_b ? b_q : r_q;

  always_comb begin
    prod_d    = prod_q;
    rem_d     = rem_q;
    r_d       = r_q;
    b_d       = b_q;
    e_d       = e_q;
    red_cnt_d = red_cnt_q;
    if (cmd_i.load) begin
      prod_d    = {{(mexp_pkg::ProdW-mexp_pkg::WordW){1'b0}}, base_i};
      rem_d     = '0;
      red_cnt_d = '0;
      e_d       = exponent_i;
      r_d       = (mod_q == mexp_pkg::ModW'(1)) ? '0 : mexp_pkg::ModW'(1);
    end
    if (cmd_i.mul_sq || cmd_i.mul_b) begin
      prod_d    = mexp_pkg::ProdW'(r_q) * mexp_pkg::ProdW'(mul_a);
      rem_d     = '0;
      red_cnt_d = '0;
    end
    if (cmd_i.red_step) begin
      prod_d    = {prod_q[mexp_pkg::ProdW-2:0], 1'b0};
      rem_d     = (trial >= {1'b0, mod_q}) ? trial_sub[mexp_pkg::ModW-1:0]
                                           : trial[mexp_pkg::ModW-1:0];
      red_cnt_d = red_cnt_q + 1'b1;
    end
    if (cmd_i.wr_b) begin
      b_d = rem_q;
    end
    if (cmd_i.wr_r) begin
      r_d = rem_q;
    end
    if (cmd_i.shift_e) begin
      e_d = {e_q[mexp_pkg::ExpBits-2:0], 1'b0};
    end
  end

  // Step counter of the reducer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_cnt_q <= '0;
    end else begin
      red_cnt_q <= red_cnt_d;
    end
  end

  // Operand and result words.
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    rem_q  <= rem_d;
    r_q    <= r_d;
    b_q    <= b_d;
    e_q    <= e_d;
  end

  assign stat_o.red_last = (red_cnt_q == mexp_pkg::RedCntW'(mexp_pkg::RedSteps - 1));
  assign stat_o.e_msb    = e_q[mexp_pkg::ExpBits-1];

  // A zero modulus admits no reduction and gives zero.
  assign power_o = (mod_q == '0) ? '0 : r_q;

  // The partial remainder stays below the modulus while reducing.
  a_rem_below_mod : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.red_step && mod_q != '0) |-> rem_q < mod_q)
    else $error("partial remainder not below modulus");

  // Loading a base or a product clears the reduction step counter.
  a_step_after_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.mul_sq || cmd_i.mul_b || cmd_i.load) |=> red_cnt_q == '0)
    else $error("reduction counter not cleared by a new operand");

endmodule

`default_nettype wire

@@ hw/rtl/mexp_ctrl.sv @@
// Controller of the modular exponentiation block: one-hot state machine
// that sequences square, multiply and reduce. Depends on mexp_pkg.
`default_nettype none

module mexp_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output logic                 busy,
  output logic                 done_o,
  input  wire mexp_pkg::stat_t stat_i,
  output mexp_pkg::cmd_t       cmd_o
);

  typedef enum logic [9:0] {
    StIdle   = 10'b00_0000_0001,
    StRedB   = 10'b00_0000_0010,
    StWrB    = 10'b00_0000_0100,
    StSq     = 10'b00_0000_1000,
    StRedSq  = 10'b00_0001_0000,
    StWrSq   = 10'b00_0010_0000,
    StMul    = 10'b00_0100_0000,
    StRedMul = 10'b00_1000_0000,
    StWrMul  = 10'b01_0000_0000,
    StDone   = 10'b10_0000_0000
  } state_e;

  state_e                         state_q, state_d;
  logic [mexp_pkg::BitCntW-1:0]   bit_q, bit_d;
  logic                           bit_last;

  assign bit_last = (bit_q == mexp_pkg::BitCntW'(mexp_pkg::ExpBits - 1));

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    bit_d   = bit_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (start) begin
          cmd_o.load = 1'b1;
          bit_d      = '0;
          state_d    = StRedB;
        end
      end
      StRedB: begin
        cmd_o.red_step = 1'b1;
        if (stat_i.red_last) state_d = StWrB;
      end
      StWrB: begin
        cmd_o.wr_b = 1'b1;
        state_d    = StSq;
      end
      StSq: begin
        cmd_o.mul_sq = 1'b1;
        state_d      = StRedSq;
      end
      StRedSq: begin
        cmd_o.red_step = 1'b1;
        if (stat_i.red_last) state_d = StWrSq;
      end
      StWrSq: begin
        cmd_o.wr_r = 1'b1;
        if (stat_i.e_msb) begin
          state_d = StMul;
        end else begin
          cmd_o.shift_e = 1'b1;
          bit_d         = bit_q + 1'b1;
          state_d       = bit_last ? StDone : StSq;
        end
      end
      StMul: begin
        cmd_o.mul_b = 1'b1;
        state_d     = StRedMul;
      end
      StRedMul: begin
        cmd_o.red_step = 1'b1;
        if (stat_i.red_last) state_d = StWrMul;
      end
      StWrMul: begin
        cmd_o.wr_r    = 1'b1;
        cmd_o.shift_e = 1'b1;
        bit_d         = bit_q + 1'b1;
        state_d       = bit_last ? StDone : StSq;
      end
      StDone: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // State and exponent bit counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      bit_q   <= '0;
    end else begin
      state_q <= state_d;
      bit_q   <= bit_d;
    end
  end

  assign busy   = (state_q != StIdle);
  assign done_o = (state_q == StDone);

  // An accepted word always begins with the base reduction.
  a_start_to_red : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> state_q == StRedB)
    else $error("accepted word did not start base reduction");

  // The result strobe lasts one cycle and frees the block.
  a_done_frees : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o && !busy)
    else $error("done strobe not followed by idle");

  // The result is only shown while the block counts as busy.
  a_done_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("done strobe while idle");

endmodule

`default_nettype wire

@@ hw/rtl/modular_exponentiation_top.sv @@
// Top level of the modular exponentiation block: controller and datapath.
// Depends on mexp_pkg, mexp_ctrl and mexp_dp.
//
//   Channel   Handshake             Payload
//   input     start / busy          base_i[31:0], exponent_i[31:0]
//   result    done_o (strobe)       power_o[30:0]
//   config    modulus_we_i          modulus_i[30:0]
//
// A word's run time, from the accepting edge to the edge that ends the done
// strobe, grows with the number of set exponent bits; the single bit-serial
// reducer, 62 steps per product, sets it.
// busy stays high from the accepting edge through the done cycle.
// The result is valid on power_o while done_o is high; the receiver
// cannot stall it. Reset restores the modulus to 1000000009 and idles.
`default_nettype none

module modular_exponentiation_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [mexp_pkg::WordW-1:0]    base_i,
  input  wire logic [mexp_pkg::ExpBits-1:0]  exponent_i,
  output logic                               done_o,
  output logic [mexp_pkg::ModW-1:0]          power_o,
  input  wire logic                          modulus_we_i,
  input  wire logic [mexp_pkg::ModW-1:0]     modulus_i
);

  mexp_pkg::cmd_t  cmd;
  mexp_pkg::stat_t stat;

  // Sequencer.
  mexp_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  // Arithmetic.
  mexp_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .modulus_we_i (modulus_we_i),
    .modulus_i    (modulus_i),
    .base_i       (base_i),
    .exponent_i   (exponent_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .power_o      (power_o)
  );

endmodule

`default_nettype wire

@@ dv/modular_exponentiation_top_tb.sv @@
// Self-checking testbench for modular_exponentiation_top: directed and random words
// over several modulus settings, checked against a square-and-multiply predictor.
// Depends on mexp_pkg and modular_exponentiation_top.
`default_nettype none

module modular_exponentiation_top_tb;

  // Cycles without any accepted word before the run is declared hung.
  localparam int unsigned WatchdogLimit = 20000;
  // Settling time after the last result, about one worst-case word.
  localparam int unsigned TailCycles = 4200;

  // Scoreboard: holds the modulus in force and the powers still owed by the block.
  class power_board;
    logic [mexp_pkg::ModW-1:0] modulus;
    logic [mexp_pkg::ModW-1:0] owed_q[$];
    int unsigned               noted;
    int unsigned               checked;
    int unsigned               mismatches;

    function new();
      modulus    = mexp_pkg::ModulusReset;
      noted      = 0;
      checked    = 0;
      mismatches = 0;
    endfunction

    function void set_modulus(logic [mexp_pkg::ModW-1:0] m);
      modulus = m;
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    // Square-and-multiply from the top exponent bit down, all products in 64 bits.
    function logic [mexp_pkg::ModW-1:0] predict_power(logic [mexp_pkg::WordW-1:0] b,
                                                      logic [mexp_pkg::ExpBits-1:0] e);
      longint unsigned m;
      longint unsigned rb;
      longint unsigned acc;
      if (modulus == '0) return '0;
      m   = modulus;
      rb  = b % m;
      acc = 1 % m;
      for (int i = mexp_pkg::ExpBits - 1; i >= 0; i--) begin
        acc = (acc * acc) % m;
        if (e[i]) acc = (acc * rb) % m;
      end
      return acc[mexp_pkg::ModW-1:0];
    endfunction

    function void note_word(logic [mexp_pkg::WordW-1:0] b, logic [mexp_pkg::ExpBits-1:0] e);
      owed_q.push_back(predict_power(b, e));
      noted++;
    endfunction

    function void check_word(logic [mexp_pkg::ModW-1:0] power);
      logic [mexp_pkg::ModW-1:0] want;
      checked++;
      if (owed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: power %0d arrived with no word outstanding", power);
        return;
      end
      want = owed_q.pop_front();
      if (power !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: power mismatch: expected %0d, got %0d", want, power);
      end
    endfunction
  endclass

  logic                         clk_i = 1'b0;
  logic                         rst_ni;
  logic                         start;
  logic                         busy;
  logic [mexp_pkg::WordW-1:0]   base_i;
  logic [mexp_pkg::ExpBits-1:0] exponent_i;
  logic                         done_o;
  logic [mexp_pkg::ModW-1:0]    power_o;
  logic                         modulus_we_i;
  logic [mexp_pkg::ModW-1:0]    modulus_i;

  power_board  board = new();
  int unsigned idle_cycles = 0;
  int unsigned settings_run = 0;
  bit          idle_on = 1'b1;

  modular_exponentiation_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .base_i      (base_i),
    .exponent_i  (exponent_i),
    .done_o      (done_o),
    .power_o     (power_o),
    .modulus_we_i(modulus_we_i),
    .modulus_i   (modulus_i)
  );

  always #5 clk_i = ~clk_i;

  // Outputs are sampled mid-cycle, away from the driving edge. The watchdog
  // restarts whenever a word is accepted on either side.
  always @(negedge clk_i) begin
    if (rst_ni && done_o) board.check_word(power_o);
    if (rst_ni && ((start && !busy) || done_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("ERROR: no word accepted for %0d cycles", WatchdogLimit);
      $display("modular_exponentiation_top test failed");
      $finish;
    end
  end

  // Idle length before a word: mostly none or short, a few long enough to
  // land anywhere inside the previous word's computation.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 75) return $urandom_range(1, 4);
    if (r < 90) return $urandom_range(5, 100);
    return $urandom_range(100, 5000);
  endfunction

  // Offers one word and returns at the edge that accepts it. Start stays high
  // between back-to-back words so it is never lowered and raised in one step.
  task automatic send_word(input logic [mexp_pkg::WordW-1:0] b,
                           input logic [mexp_pkg::ExpBits-1:0] e);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      start      <= 1'b0;
      base_i     <= $urandom;
      exponent_i <= $urandom;
      repeat (gap) @(posedge clk_i);
    end
    start      <= 1'b1;
    base_i     <= b;
    exponent_i <= e;
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    board.note_word(b, e);
  endtask

  // Stops offering words and waits until every owed power is back and the block is idle.
  task automatic drain_words();
    start <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Writes the modulus register; only called while the block is idle.
  task automatic write_modulus(input logic [mexp_pkg::ModW-1:0] m);
    modulus_we_i <= 1'b1;
    modulus_i    <= m;
    @(posedge clk_i);
    modulus_we_i <= 1'b0;
    modulus_i    <= mexp_pkg::ModW'($urandom);
    board.set_modulus(m);
    settings_run++;
  endtask

  // One random phase under a given modulus, with a mix of edge values and
  // fully random bases and exponents.
  task automatic run_phase(input logic [mexp_pkg::ModW-1:0] m, input int unsigned count,
                           input bit with_idle);
    logic [mexp_pkg::WordW-1:0]   b;
    logic [mexp_pkg::ExpBits-1:0] e;
    write_modulus(m);
    idle_on = with_idle;
    repeat (count) begin
      case ($urandom_range(0, 9))
        0:       b = '0;
        1:       b = '1;
        2:       b = {1'b0, m} * $urandom_range(0, 2);
        3:       b = {1'b0, m} - 32'd1;
        default: b = $urandom;
      endcase
      case ($urandom_range(0, 9))
        0:       e = '0;
        1:       e = '1;
        2:       e = $urandom_range(0, 15);
        3:       e = mexp_pkg::ExpBits'(1) << $urandom_range(0, mexp_pkg::ExpBits - 1);
        default: e = $urandom;
      endcase
      send_word(b, e);
    end
    drain_words();
  endtask

  initial begin
    logic [mexp_pkg::ModW-1:0] m;
    rst_ni       = 1'b0;
    start        = 1'b0;
    base_i       = '0;
    exponent_i   = '0;
    modulus_we_i = 1'b0;
    modulus_i    = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed words under the reset modulus: zero exponent, extreme fields,
    // a base equal to the modulus and one just below it.
    idle_on = 1'b1;
    send_word('0, '0);
    send_word('0, 32'd1);
    send_word(32'd1, '0);
    send_word('1, '1);
    send_word('1, '0);
    send_word(32'd1000000009, 32'd5);
    send_word(32'd1000000008, 32'd2);
    send_word(32'd2, 32'h8000_0000);
    send_word(32'd3, 32'd1);
    send_word(32'h7FFF_FFFF, 32'hAAAA_AAAA);
    send_word(32'h8000_0000, 32'h5555_5555);
    drain_words();
    settings_run++;

    // Modulus of one: every power is zero, even for a zero exponent.
    write_modulus(31'd1);
    send_word(32'd5, '0);
    send_word('1, '1);
    drain_words();

    // Largest modulus: residues use every bit of the result.
    write_modulus('1);
    send_word(32'h7FFF_FFFE, '1);
    send_word(32'h7FFF_FFFF, 32'd3);
    send_word('1, 32'd2);
    send_word(32'h1234_5678, 32'h8765_4321);
    drain_words();

    // Modulus of two.
    write_modulus(31'd2);
    send_word(32'd3, '0);
    send_word(32'd4, 32'd7);
    send_word(32'd5, '1);
    drain_words();

    // Random phases over a spread of moduli, two of them sending words back to back without idling.
    run_phase(mexp_pkg::ModW'($urandom), 18, 1'b1);
    run_phase(31'd7, 14, 1'b0);
    run_phase('1, 18, 1'b1);
    run_phase(mexp_pkg::ModW'($urandom_range(2, 1000)), 16, 1'b1);
    run_phase(31'd1000000007, 16, 1'b0);
    m = mexp_pkg::ModW'($urandom);
    m[mexp_pkg::ModW-1] = 1'b1;
    run_phase(m, 16, 1'b1);
    run_phase(31'd1, 6, 1'b1);
    run_phase(mexp_pkg::ModulusReset, 14, 1'b1);

    // Let any stray strobe show up before judging.
    repeat (TailCycles) @(posedge clk_i);

    $display("Summary: %0d words sent under %0d modulus settings, %0d powers checked.",
             board.noted, settings_run, board.checked);
    if (board.pending() != 0)
      $display("ERROR: %0d powers never arrived", board.pending());
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("modular_exponentiation_top test passed");
    end else begin
      $display("Mismatches: %0d", board.mismatches);
      $display("modular_exponentiation_top test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ modular_exponentiation_top.f @@
hw/rtl/mexp_pkg.sv
hw/rtl/mexp_dp.sv
hw/rtl/mexp_ctrl.sv
hw/rtl/modular_exponentiation_top.sv
dv/modular_exponentiation_top_tb.sv
